// ===== rtl/qrv_pkg.sv =====
// qrv_pkg: widths and data types shared by the quaternion rotation pipeline.
// No dependencies; every rtl file but qrv_checker refers to it by scoped names.
package qrv_pkg;

	localparam int DATA_W    = 16;                 // field width, two's complement
	localparam int FRAC_BITS = 14;                 // quaternion fraction bits
	localparam int PROD1_W   = 2 * DATA_W;         // q * v product
	localparam int P_W       = PROD1_W + 1;        // sum of three q * v products
	localparam int PROD2_W   = P_W + DATA_W;       // p * q product
	localparam int ACC_W     = PROD2_W + 1;        // sum of four p * q products
	localparam int SHIFT     = 2 * FRAC_BITS;      // scale of the final sum
	localparam int RES_W     = ACC_W - SHIFT;      // rounded value before clamping

	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (SHIFT - 1);
	localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct packed {
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		logic signed [DATA_W-1:0] z;
		logic signed [DATA_W-1:0] w;
	} quat_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		logic signed [DATA_W-1:0] z;
	} vec_t;

	// P = Q * V, exact
	typedef struct packed {
		logic signed [P_W-1:0] x;
		logic signed [P_W-1:0] y;
		logic signed [P_W-1:0] z;
		logic signed [P_W-1:0] w;
	} pquat_t;

	// R = P * conj(Q), rounded and scaled back, not yet clamped
	typedef struct packed {
		logic signed [RES_W-1:0] x;
		logic signed [RES_W-1:0] y;
		logic signed [RES_W-1:0] z;
	} rvec_t;

endpackage

// ===== rtl/qrv_qv_mul.sv =====
// qrv_qv_mul: stages 1 and 2, P = Q * (V, 0) as an exact Hamilton product.
// Stage 1 holds the twelve q*v products, stage 2 the sums. Uses qrv_pkg.
module qrv_qv_mul (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  qrv_pkg::quat_t       q_in,
	input  qrv_pkg::vec_t        v_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output qrv_pkg::quat_t       q_out,
	output qrv_pkg::pquat_t      p_out
);

	typedef logic signed [qrv_pkg::PROD1_W-1:0] prod1_t;
	typedef logic signed [qrv_pkg::P_W-1:0]     psum_t;

	logic                                 valid_s1, valid_s2;
	logic                                 ready_s1, ready_s2;
	logic signed [qrv_pkg::PROD1_W-1:0]   prod_s1 [12];
	qrv_pkg::quat_t                       q_s1, q_s2;
	qrv_pkg::pquat_t                      p_s2;
	logic signed [qrv_pkg::PROD1_W-1:0]   prod [12];
	qrv_pkg::pquat_t                      p_sum;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_comb begin
		// x part
		prod[0]  = prod1_t'(q_in.w) * prod1_t'(v_in.x);
		prod[1]  = prod1_t'(q_in.y) * prod1_t'(v_in.z);
		prod[2]  = prod1_t'(q_in.z) * prod1_t'(v_in.y);
		// y part
		prod[3]  = prod1_t'(q_in.w) * prod1_t'(v_in.y);
		prod[4]  = prod1_t'(q_in.x) * prod1_t'(v_in.z);
		prod[5]  = prod1_t'(q_in.z) * prod1_t'(v_in.x);
		// z part
		prod[6]  = prod1_t'(q_in.w) * prod1_t'(v_in.z);
		prod[7]  = prod1_t'(q_in.x) * prod1_t'(v_in.y);
		prod[8]  = prod1_t'(q_in.y) * prod1_t'(v_in.x);
		// w part (dot product, negated in stage 2)
		prod[9]  = prod1_t'(q_in.x) * prod1_t'(v_in.x);
		prod[10] = prod1_t'(q_in.y) * prod1_t'(v_in.y);
		prod[11] = prod1_t'(q_in.z) * prod1_t'(v_in.z);
	end

	always_comb begin
		p_sum.x = psum_t'(prod_s1[0]) + psum_t'(prod_s1[1]) - psum_t'(prod_s1[2]);
		p_sum.y = psum_t'(prod_s1[3]) - psum_t'(prod_s1[4]) + psum_t'(prod_s1[5]);
		p_sum.z = psum_t'(prod_s1[6]) + psum_t'(prod_s1[7]) - psum_t'(prod_s1[8]);
		p_sum.w = -psum_t'(prod_s1[9]) - psum_t'(prod_s1[10]) - psum_t'(prod_s1[11]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			prod_s1 <= prod;
			q_s1    <= q_in;
		end
		if (ready_s2 && valid_s1) begin
			p_s2 <= p_sum;
			q_s2 <= q_s1;
		end
	end

	assign out_valid = valid_s2;
	assign q_out     = q_s2;
	assign p_out     = p_s2;

endmodule

// ===== rtl/qrv_pq_mul.sv =====
// qrv_pq_mul: stages 3 and 4, R = P * conj(Q), then round to nearest and scale.
// Stage 3 holds the twelve p*q products, stage 4 the rounded sums. Uses qrv_pkg.
module qrv_pq_mul (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  qrv_pkg::quat_t       q_in,
	input  qrv_pkg::pquat_t      p_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output qrv_pkg::rvec_t       r_out
);

	typedef logic signed [qrv_pkg::PROD2_W-1:0] prod2_t;
	typedef logic signed [qrv_pkg::ACC_W-1:0]   acc_t;

	logic                                 valid_s3, valid_s4;
	logic                                 ready_s3, ready_s4;
	logic signed [qrv_pkg::PROD2_W-1:0]   prod_s3 [12];
	qrv_pkg::rvec_t                       r_s4;
	logic signed [qrv_pkg::PROD2_W-1:0]   prod [12];
	logic signed [qrv_pkg::ACC_W-1:0]     acc_x, acc_y, acc_z;
	qrv_pkg::rvec_t                       r_rnd;

	assign ready_s4 = !valid_s4 || out_ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign in_ready = ready_s3;

	always_comb begin
		prod[0]  = prod2_t'(p_in.x) * prod2_t'(q_in.w);
		prod[1]  = prod2_t'(p_in.w) * prod2_t'(q_in.x);
		prod[2]  = prod2_t'(p_in.y) * prod2_t'(q_in.z);
		prod[3]  = prod2_t'(p_in.z) * prod2_t'(q_in.y);
		prod[4]  = prod2_t'(p_in.y) * prod2_t'(q_in.w);
		prod[5]  = prod2_t'(p_in.w) * prod2_t'(q_in.y);
		prod[6]  = prod2_t'(p_in.x) * prod2_t'(q_in.z);
		prod[7]  = prod2_t'(p_in.z) * prod2_t'(q_in.x);
		prod[8]  = prod2_t'(p_in.z) * prod2_t'(q_in.w);
		prod[9]  = prod2_t'(p_in.w) * prod2_t'(q_in.z);
		prod[10] = prod2_t'(p_in.x) * prod2_t'(q_in.y);
		prod[11] = prod2_t'(p_in.y) * prod2_t'(q_in.x);
	end

	// half an lsb added, then the low SHIFT bits dropped: ties go up
	always_comb begin
		acc_x = acc_t'(prod_s3[0]) - acc_t'(prod_s3[1]) - acc_t'(prod_s3[2])
			+ acc_t'(prod_s3[3]) + qrv_pkg::ROUND_HALF;
		acc_y = acc_t'(prod_s3[4]) - acc_t'(prod_s3[5]) + acc_t'(prod_s3[6])
			- acc_t'(prod_s3[7]) + qrv_pkg::ROUND_HALF;
		acc_z = acc_t'(prod_s3[8]) - acc_t'(prod_s3[9]) - acc_t'(prod_s3[10])
			+ acc_t'(prod_s3[11]) + qrv_pkg::ROUND_HALF;
		r_rnd.x = acc_x[qrv_pkg::ACC_W-1:qrv_pkg::SHIFT];
		r_rnd.y = acc_y[qrv_pkg::ACC_W-1:qrv_pkg::SHIFT];
		r_rnd.z = acc_z[qrv_pkg::ACC_W-1:qrv_pkg::SHIFT];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s3) valid_s3 <= in_valid;
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && in_valid) prod_s3 <= prod;
		if (ready_s4 && valid_s3) r_s4 <= r_rnd;
	end

	assign out_valid = valid_s4;
	assign r_out     = r_s4;

endmodule

// ===== rtl/qrv_sat.sv =====
// qrv_sat: stage 5, clamps each component to DATA_W bits and flags any clamp.
// This stage is the output register of the block. Uses qrv_pkg.
module qrv_sat (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  qrv_pkg::rvec_t       r_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output qrv_pkg::vec_t        v_out,
	output logic                 clip_out
);

	localparam int HI = qrv_pkg::RES_W - 1;
	localparam int LO = qrv_pkg::DATA_W - 1;

	logic                 valid_s5;
	logic                 ready_s5;
	qrv_pkg::vec_t        v_s5;
	logic                 clip_s5;
	logic                 ovf_x, ovf_y, ovf_z;
	qrv_pkg::vec_t        v_sat;

	assign ready_s5 = !valid_s5 || out_ready;
	assign in_ready = ready_s5;

	// overflow when the bits above the result are not all copies of its sign
	always_comb begin
		ovf_x = !((&r_in.x[HI:LO]) || !(|r_in.x[HI:LO]));
		ovf_y = !((&r_in.y[HI:LO]) || !(|r_in.y[HI:LO]));
		ovf_z = !((&r_in.z[HI:LO]) || !(|r_in.z[HI:LO]));
		v_sat.x = ovf_x ? (r_in.x[HI] ? qrv_pkg::SAT_MIN : qrv_pkg::SAT_MAX) : r_in.x[LO:0];
		v_sat.y = ovf_y ? (r_in.y[HI] ? qrv_pkg::SAT_MIN : qrv_pkg::SAT_MAX) : r_in.y[LO:0];
		v_sat.z = ovf_z ? (r_in.z[HI] ? qrv_pkg::SAT_MIN : qrv_pkg::SAT_MAX) : r_in.z[LO:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (ready_s5) begin
			valid_s5 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s5 && in_valid) begin
			v_s5    <= v_sat;
			clip_s5 <= ovf_x || ovf_y || ovf_z;
		end
	end

	assign out_valid = valid_s5;
	assign v_out     = v_s5;
	assign clip_out  = clip_s5;

endmodule

// ===== rtl/quaternion_rotate_vector_core.sv =====
// quaternion_rotate_vector_core: top level, rotates a vector by a quaternion,
// R = Q * V * conj(Q). Depends on qrv_pkg, qrv_qv_mul, qrv_pq_mul, qrv_sat.
//
//  channel | signals                                   | accepted when
//  --------+-------------------------------------------+----------------------
//  in      | in_valid in_ready quat_x/y/z/w vec_x/y/z  | in_valid & in_ready
//  out     | out_valid out_ready rot_x/y/z clipped     | out_valid & out_ready
//
// Five register stages: q*v products, P sums, p*q products, rounded R sums,
// saturation (the output register). With out_ready high one item is taken
// per cycle.
// Reset (arst_n low) clears only the stage valid bits; data registers keep junk.
// Each stage takes a new item when it is empty or its successor moves, so a
// stall at out_ready fills bubbles first and never drops or repeats an item.
module quaternion_rotate_vector_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [15:0]  quat_x,
	input  logic signed [15:0]  quat_y,
	input  logic signed [15:0]  quat_z,
	input  logic signed [15:0]  quat_w,
	input  logic signed [15:0]  vec_x,
	input  logic signed [15:0]  vec_y,
	input  logic signed [15:0]  vec_z,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [15:0]  rot_x,
	output logic signed [15:0]  rot_y,
	output logic signed [15:0]  rot_z,
	output logic                clipped
);

	qrv_pkg::quat_t   q_in;
	qrv_pkg::vec_t    v_in;

	// between stage 2 and stage 3
	logic             p_valid, p_ready;
	qrv_pkg::quat_t   p_q;
	qrv_pkg::pquat_t  p_val;

	// between stage 4 and stage 5
	logic             r_valid, r_ready;
	qrv_pkg::rvec_t   r_val;

	qrv_pkg::vec_t    v_res;

	assign q_in = '{x: quat_x, y: quat_y, z: quat_z, w: quat_w};
	assign v_in = '{x: vec_x, y: vec_y, z: vec_z};

	// P = Q * (V, 0); V's scalar is taken as zero, which leaves x/y/z unchanged
	qrv_qv_mul u_qv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.q_in      (q_in),
		.v_in      (v_in),
		.out_valid (p_valid),
		.out_ready (p_ready),
		.q_out     (p_q),
		.p_out     (p_val)
	);

	// R = P * conj(Q), scaled by 2^-28 with round half up
	qrv_pq_mul u_pq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (p_valid),
		.in_ready  (p_ready),
		.q_in      (p_q),
		.p_in      (p_val),
		.out_valid (r_valid),
		.out_ready (r_ready),
		.r_out     (r_val)
	);

	// clamp to 16 bits; clipped is set if any component was clamped
	qrv_sat u_sat (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (r_valid),
		.in_ready  (r_ready),
		.r_in      (r_val),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.v_out     (v_res),
		.clip_out  (clipped)
	);

	assign rot_x = v_res.x;
	assign rot_y = v_res.y;
	assign rot_z = v_res.z;

endmodule

// ===== rtl/qrv_checker.sv =====
// qrv_checker: port-level assertions for quaternion_rotate_vector_core,
// attached with the bind below. Uses only the top-level ports.
module qrv_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic signed [15:0]  rot_x,
	input  logic signed [15:0]  rot_y,
	input  logic signed [15:0]  rot_z,
	input  logic                clipped
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rot_x) && $stable(rot_y)
			&& $stable(rot_z) && $stable(clipped))
		else $error("result changed while stalled");

	// a clamped result has at least one component at a rail
	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |-> rot_x == 16'sh7fff || rot_x == 16'sh8000
			|| rot_y == 16'sh7fff || rot_y == 16'sh8000
			|| rot_z == 16'sh7fff || rot_z == 16'sh8000)
		else $error("clipped set but no component saturated");

	// with the consumer ready the pipeline never pushes back
	a_no_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output is ready");

	// with out_ready held high and no reset, an accepted item reaches the output
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(in_valid && in_ready, 5) && $past(arst_n, 5) && $past(arst_n, 4)
			&& $past(arst_n, 3) && $past(arst_n, 2) && $past(arst_n, 1)
			&& $past(out_ready, 4) && $past(out_ready, 3)
			&& $past(out_ready, 2) && $past(out_ready, 1) |-> out_valid)
		else $error("result missing after five unstalled cycles");

endmodule

bind quaternion_rotate_vector_core qrv_checker u_qrv_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.rot_x     (rot_x),
	.rot_y     (rot_y),
	.rot_z     (rot_z),
	.clipped   (clipped)
);
